// ===== hdl/assert_macros.svh =====
// Assertion macros for the checker file of the polygon clipper.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check that is off while reset is high.
`define RPC_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("polygon clipper check failed");

// Concurrent check that also runs through reset.
`define RPC_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("polygon clipper reset check failed");

`endif

// ===== hdl/rpc_pkg.sv =====
// Types and constants of the rectangle polygon clipper.
`default_nettype none

package rpc_pkg;

   localparam int NUM_STAGES = 4;
   localparam int NUM_LEVELS = NUM_STAGES + 1;
   localparam int STG_W      = $clog2(NUM_STAGES);
   localparam int LVL_W      = $clog2(NUM_LEVELS);
   localparam int CLOSE_W    = $clog2(NUM_STAGES + 1);
   localparam int MAX_OUT    = 16;
   localparam int OUT_CNT_W  = $clog2(MAX_OUT + 1);
   localparam int REG_IDX_W  = 2;

   typedef enum logic [REG_IDX_W-1:0] {
      REG_BOX_X0,
      REG_BOX_Y0,
      REG_BOX_X1,
      REG_BOX_Y1
   } rpc_reg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SELECT,
      ST_MUL,
      ST_DIV,
      ST_FIN
   } rpc_state_type;

endpackage

`default_nettype wire

// ===== hdl/rpc_ifs.sv =====
// Valid/ready channel interfaces for polygon vertices and clipped results.
`default_nettype none

interface rpc_req_if #(parameter int COORD_BITS = 16);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] vertex_x;
   logic signed [COORD_BITS-1:0] vertex_y;
   logic                         last_vertex;

   modport source (output valid, vertex_x, vertex_y, last_vertex, input ready);
   modport sink (input valid, vertex_x, vertex_y, last_vertex, output ready);
endinterface

interface rpc_rsp_if #(parameter int COORD_BITS = 16);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] out_x;
   logic signed [COORD_BITS-1:0] out_y;
   logic                         out_last;
   logic                         empty_result;

   modport source (output valid, out_x, out_y, out_last, empty_result, input ready);
   modport sink (input valid, out_x, out_y, out_last, empty_result, output ready);
endinterface

`default_nettype wire

// ===== hdl/rect_polygon_clipper.sv =====
// Streaming Sutherland-Hodgman clipper of a polygon against a rectangle.
//
//   channel   direction  payload                                 handshake
//   req_bus   in         vertex_x, vertex_y, last_vertex         valid/ready
//   rsp_bus   out        out_x, out_y, out_last, empty_result    valid/ready
//   csr_*     in         csr_index, csr_wdata                    csr_wr_en
//
// One vertex at a time: req_bus.ready is high only while the sequencer is idle.
// The sequencer moves each edge item through the four stages; a boundary crossing
// is computed in the shared shift-add multiplier and then the restoring divider.
// Reset is synchronous and clears all stages, the held-back vertex and the box.
// A full result register stalls the sequencer; a new vertex is still taken
// while the last result of the previous one waits.
`default_nettype none

module rect_polygon_clipper #(
   parameter int COORD_BITS = 16
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   rpc_req_if.sink                             req_bus,
   rpc_rsp_if.source                           rsp_bus,
   input  wire logic                           csr_wr_en,
   input  wire logic [rpc_pkg::REG_IDX_W-1:0]  csr_index,
   input  wire logic [COORD_BITS-1:0]          csr_wdata
);

   import rpc_pkg::*;

   localparam int W  = COORD_BITS;
   localparam int AW = W + 1;
   localparam int PW = 2 * AW;
   localparam int BW = W + 3;
   localparam int CW = $clog2(PW);

   rpc_state_type state_ff, state_in;

   logic signed [W-1:0] box_x0_ff, box_y0_ff, box_x1_ff, box_y1_ff;
   logic signed [W-1:0] box_x0_in, box_y0_in, box_x1_in, box_y1_in;
   logic signed [W-1:0] lim [NUM_STAGES];

   logic signed [W-1:0] pend_x_ff [NUM_LEVELS][2];
   logic signed [W-1:0] pend_y_ff [NUM_LEVELS][2];
   logic [1:0]          pend_n_ff [NUM_LEVELS];
   logic signed [W-1:0] pend_x_in [NUM_LEVELS][2];
   logic signed [W-1:0] pend_y_in [NUM_LEVELS][2];
   logic [1:0]          pend_n_in [NUM_LEVELS];

   logic signed [W-1:0]   first_x_ff [NUM_STAGES], first_y_ff [NUM_STAGES];
   logic signed [W-1:0]   prev_x_ff [NUM_STAGES], prev_y_ff [NUM_STAGES];
   logic signed [W-1:0]   first_x_in [NUM_STAGES], first_y_in [NUM_STAGES];
   logic signed [W-1:0]   prev_x_in [NUM_STAGES], prev_y_in [NUM_STAGES];
   logic [NUM_STAGES-1:0] started_ff, started_in;

   logic                 hold_valid_ff, hold_valid_in;
   logic signed [W-1:0]  hold_x_ff, hold_y_ff, hold_x_in, hold_y_in;
   logic [OUT_CNT_W-1:0] coll_cnt_ff, coll_cnt_in;
   logic                 last_ff, last_in;
   logic                 closing_ff, closing_in;
   logic [CLOSE_W-1:0]   close_idx_ff, close_idx_in;

   logic [STG_W-1:0]    ed_lvl_ff, ed_lvl_in;
   logic signed [W-1:0] ed_qx_ff, ed_qy_ff, ed_qx_in, ed_qy_in;
   logic                ed_qin_ff, ed_qin_in;
   logic signed [W-1:0] ed_b_ff, ed_b_in;
   logic signed [W-1:0] ed_o1_ff, ed_o1_in;
   logic                ed_neg_ff, ed_neg_in;
   logic [AW-1:0]       ed_ud_ff, ed_ud_in;
   logic [AW-1:0]       ed_uc_ff, ed_uc_in;
   logic [PW-1:0]       acc_ff, acc_in;
   logic [AW-1:0]       rem_ff, rem_in;
   logic [CW-1:0]       cnt_ff, cnt_in;

   logic                out_valid_ff, out_valid_in;
   logic signed [W-1:0] out_x_ff, out_y_ff, out_x_in, out_y_in;
   logic                out_last_ff, out_last_in;
   logic                out_empty_ff, out_empty_in;
   logic                out_free;

   // level selection and edge operands
   logic                sel_found;
   logic [LVL_W-1:0]    sel_lvl;
   logic [STG_W-1:0]    e_lvl;
   logic signed [W-1:0] e_px, e_py, e_qx, e_qy;
   logic signed [W-1:0] e_axp, e_axq, e_otp, e_otq, e_b;
   logic                e_pin, e_qin;
   logic signed [AW-1:0] e_da, e_dc, e_dd;
   logic [AW-1:0]       e_ua, e_uc, e_ud;

   // sequencer temporaries
   logic                edge_en;
   logic                pop_en;
   logic                push_en, push_two;
   logic [LVL_W-1:0]    push_lvl;
   logic signed [W-1:0] push0_x, push0_y, push1_x, push1_y;
   logic [AW:0]         mul_sum;
   logic [AW:0]         div_rsh;
   logic                div_ge;
   logic signed [BW-1:0] fin_o1, fin_q, fin_base, fin_adj;
   logic signed [W-1:0] fin_res;

   assign req_bus.ready        = (state_ff == ST_IDLE);
   assign rsp_bus.valid        = out_valid_ff;
   assign rsp_bus.out_x        = out_x_ff;
   assign rsp_bus.out_y        = out_y_ff;
   assign rsp_bus.out_last     = out_last_ff;
   assign rsp_bus.empty_result = out_empty_ff;
   assign out_free             = !out_valid_ff || rsp_bus.ready;

   always_comb begin
      box_x0_in = box_x0_ff;
      box_y0_in = box_y0_ff;
      box_x1_in = box_x1_ff;
      box_y1_in = box_y1_ff;
      if (csr_wr_en) begin
         unique case (rpc_reg_type'(csr_index))
            REG_BOX_X0: box_x0_in = csr_wdata;
            REG_BOX_Y0: box_y0_in = csr_wdata;
            REG_BOX_X1: box_x1_in = csr_wdata;
            REG_BOX_Y1: box_y1_in = csr_wdata;
         endcase
      end
   end

   always_comb begin
      lim[0] = (box_x0_ff < box_x1_ff) ? box_x0_ff : box_x1_ff;
      lim[1] = (box_x0_ff < box_x1_ff) ? box_x1_ff : box_x0_ff;
      lim[2] = (box_y0_ff < box_y1_ff) ? box_y0_ff : box_y1_ff;
      lim[3] = (box_y0_ff < box_y1_ff) ? box_y1_ff : box_y0_ff;
   end

   // deepest level with pending work goes first
   always_comb begin
      sel_found = 1'b0;
      sel_lvl   = '0;
      for (int l = 0; l < NUM_LEVELS; l++) begin
         if (pend_n_ff[l] != 2'd0) begin
            sel_found = 1'b1;
            sel_lvl   = LVL_W'(l);
         end
      end
   end

   always_comb begin
      e_lvl = sel_found ? sel_lvl[STG_W-1:0] : close_idx_ff[STG_W-1:0];
      e_px  = prev_x_ff[e_lvl];
      e_py  = prev_y_ff[e_lvl];
      e_qx  = sel_found ? pend_x_ff[sel_lvl][0] : first_x_ff[e_lvl];
      e_qy  = sel_found ? pend_y_ff[sel_lvl][0] : first_y_ff[e_lvl];
      // bottom and top stages test y and interpolate x
      e_axp = e_lvl[1] ? e_py : e_px;
      e_axq = e_lvl[1] ? e_qy : e_qx;
      e_otp = e_lvl[1] ? e_px : e_py;
      e_otq = e_lvl[1] ? e_qx : e_qy;
      e_b   = lim[e_lvl];
      e_pin = e_lvl[0] ? (e_axp <= e_b) : (e_axp >= e_b);
      e_qin = e_lvl[0] ? (e_axq <= e_b) : (e_axq >= e_b);
      e_da  = {e_b[W-1], e_b} - {e_axp[W-1], e_axp};
      e_dc  = {e_otq[W-1], e_otq} - {e_otp[W-1], e_otp};
      e_dd  = {e_axq[W-1], e_axq} - {e_axp[W-1], e_axp};
      e_ua  = e_da[AW-1] ? AW'(~e_da + 1'b1) : AW'(e_da);
      e_uc  = e_dc[AW-1] ? AW'(~e_dc + 1'b1) : AW'(e_dc);
      e_ud  = e_dd[AW-1] ? AW'(~e_dd + 1'b1) : AW'(e_dd);
   end

   always_comb begin
      state_in      = state_ff;
      pend_x_in     = pend_x_ff;
      pend_y_in     = pend_y_ff;
      pend_n_in     = pend_n_ff;
      first_x_in    = first_x_ff;
      first_y_in    = first_y_ff;
      prev_x_in     = prev_x_ff;
      prev_y_in     = prev_y_ff;
      started_in    = started_ff;
      hold_valid_in = hold_valid_ff;
      hold_x_in     = hold_x_ff;
      hold_y_in     = hold_y_ff;
      coll_cnt_in   = coll_cnt_ff;
      last_in       = last_ff;
      closing_in    = closing_ff;
      close_idx_in  = close_idx_ff;
      ed_lvl_in     = ed_lvl_ff;
      ed_qx_in      = ed_qx_ff;
      ed_qy_in      = ed_qy_ff;
      ed_qin_in     = ed_qin_ff;
      ed_b_in       = ed_b_ff;
      ed_o1_in      = ed_o1_ff;
      ed_neg_in     = ed_neg_ff;
      ed_ud_in      = ed_ud_ff;
      ed_uc_in      = ed_uc_ff;
      acc_in        = acc_ff;
      rem_in        = rem_ff;
      cnt_in        = cnt_ff;
      out_valid_in  = out_valid_ff && !rsp_bus.ready;
      out_x_in      = out_x_ff;
      out_y_in      = out_y_ff;
      out_last_in   = out_last_ff;
      out_empty_in  = out_empty_ff;
      edge_en       = 1'b0;
      pop_en        = 1'b0;
      push_en       = 1'b0;
      push_two      = 1'b0;
      push_lvl      = LVL_W'(e_lvl) + LVL_W'(1);
      push0_x       = e_px;
      push0_y       = e_py;
      push1_x       = e_qx;
      push1_y       = e_qy;
      mul_sum       = {1'b0, acc_ff[PW-1:AW]};
      div_rsh       = {rem_ff, acc_ff[PW-1]};
      div_ge        = 1'b0;
      fin_o1        = {{3{ed_o1_ff[W-1]}}, ed_o1_ff};
      fin_q         = {2'b00, acc_ff[AW-1:0]};
      fin_base      = '0;
      fin_adj       = '0;
      fin_res       = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) begin
               pend_x_in[0][0] = req_bus.vertex_x;
               pend_y_in[0][0] = req_bus.vertex_y;
               pend_n_in[0]    = 2'd1;
               last_in         = req_bus.last_vertex;
               closing_in      = req_bus.last_vertex;
               close_idx_in    = '0;
               coll_cnt_in     = hold_valid_ff ? OUT_CNT_W'(1) : '0;
               state_in        = ST_SELECT;
            end
         end

         ST_SELECT: begin
            priority if (sel_found && sel_lvl == LVL_W'(NUM_STAGES)) begin
               // collect a clipped vertex, keeping the newest one held back, or drop it once MAX_OUT are collected
               if (coll_cnt_ff >= OUT_CNT_W'(MAX_OUT)) begin
                  pop_en = 1'b1;
               end else if (!hold_valid_ff) begin
                  hold_valid_in = 1'b1;
                  hold_x_in     = pend_x_ff[sel_lvl][0];
                  hold_y_in     = pend_y_ff[sel_lvl][0];
                  coll_cnt_in   = coll_cnt_ff + 1'b1;
                  pop_en        = 1'b1;
               end else if (out_free) begin
                  out_valid_in = 1'b1;
                  out_x_in     = hold_x_ff;
                  out_y_in     = hold_y_ff;
                  out_last_in  = 1'b0;
                  out_empty_in = 1'b0;
                  hold_x_in    = pend_x_ff[sel_lvl][0];
                  hold_y_in    = pend_y_ff[sel_lvl][0];
                  coll_cnt_in  = coll_cnt_ff + 1'b1;
                  pop_en       = 1'b1;
               end
            end else if (sel_found) begin
               pop_en           = 1'b1;
               prev_x_in[e_lvl] = e_qx;
               prev_y_in[e_lvl] = e_qy;
               if (!started_ff[e_lvl]) begin
                  started_in[e_lvl] = 1'b1;
                  first_x_in[e_lvl] = e_qx;
                  first_y_in[e_lvl] = e_qy;
               end else begin
                  edge_en = 1'b1;
               end
            end else if (closing_ff && close_idx_ff < CLOSE_W'(NUM_STAGES)) begin
               // closing edge back to the first vertex, one stage at a time
               close_idx_in = close_idx_ff + 1'b1;
               if (started_ff[e_lvl]) begin
                  started_in[e_lvl] = 1'b0;
                  edge_en           = 1'b1;
               end
            end else if (!last_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               out_valid_in  = 1'b1;
               out_x_in      = hold_valid_ff ? hold_x_ff : '0;
               out_y_in      = hold_valid_ff ? hold_y_ff : '0;
               out_last_in   = 1'b1;
               out_empty_in  = !hold_valid_ff;
               hold_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end

            if (edge_en) begin
               if (e_pin && e_qin) begin
                  push_en = 1'b1;
                  push0_x = e_qx;
                  push0_y = e_qy;
               end else if (e_pin || e_qin) begin
                  if (e_dd == '0) begin
                     push_en  = 1'b1;
                     push_two = e_qin;
                  end else begin
                     ed_lvl_in = e_lvl;
                     ed_qx_in  = e_qx;
                     ed_qy_in  = e_qy;
                     ed_qin_in = e_qin;
                     ed_b_in   = e_b;
                     ed_o1_in  = e_otp;
                     ed_neg_in = e_da[AW-1] ^ e_dc[AW-1] ^ e_dd[AW-1];
                     ed_ud_in  = e_ud;
                     ed_uc_in  = e_uc;
                     acc_in    = {{AW{1'b0}}, e_ua};
                     cnt_in    = '0;
                     state_in  = ST_MUL;
                  end
               end
            end
         end

         ST_MUL: begin
            // shift-add, one multiplier bit per cycle
            if (acc_ff[0]) begin
               mul_sum = {1'b0, acc_ff[PW-1:AW]} + {1'b0, ed_uc_ff};
            end
            acc_in = {mul_sum, acc_ff[AW-1:1]};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CW'(AW - 1)) begin
               cnt_in   = '0;
               rem_in   = '0;
               state_in = ST_DIV;
            end
         end

         ST_DIV: begin
            // restoring division, one quotient bit per cycle
            div_ge = div_rsh >= {1'b0, ed_ud_ff};
            rem_in = div_ge ? AW'(div_rsh - {1'b0, ed_ud_ff}) : AW'(div_rsh);
            acc_in = {acc_ff[PW-2:0], div_ge};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CW'(PW - 1)) begin
               state_in = ST_FIN;
            end
         end

         ST_FIN: begin
            fin_base = ed_neg_ff ? fin_o1 - fin_q : fin_o1 + fin_q;
            fin_adj  = fin_base;
            // round the exact intersection coordinate toward zero
            if (rem_ff != '0) begin
               if (!ed_neg_ff && fin_base[BW-1]) begin
                  fin_adj = fin_base + BW'(1);
               end else if (ed_neg_ff && !fin_base[BW-1] && fin_base != '0) begin
                  fin_adj = fin_base - BW'(1);
               end
            end
            fin_res  = fin_adj[W-1:0];
            push_en  = 1'b1;
            push_two = ed_qin_ff;
            push_lvl = LVL_W'(ed_lvl_ff) + LVL_W'(1);
            push0_x  = ed_lvl_ff[1] ? fin_res : ed_b_ff;
            push0_y  = ed_lvl_ff[1] ? ed_b_ff : fin_res;
            push1_x  = ed_qx_ff;
            push1_y  = ed_qy_ff;
            state_in = ST_SELECT;
         end

         default: state_in = ST_IDLE;
      endcase

      if (pop_en) begin
         pend_x_in[sel_lvl][0] = pend_x_ff[sel_lvl][1];
         pend_y_in[sel_lvl][0] = pend_y_ff[sel_lvl][1];
         pend_n_in[sel_lvl]    = pend_n_ff[sel_lvl] - 1'b1;
      end
      if (push_en) begin
         pend_x_in[push_lvl][0] = push0_x;
         pend_y_in[push_lvl][0] = push0_y;
         pend_x_in[push_lvl][1] = push1_x;
         pend_y_in[push_lvl][1] = push1_y;
         pend_n_in[push_lvl]    = push_two ? 2'd2 : 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         box_x0_ff     <= '0;
         box_y0_ff     <= '0;
         box_x1_ff     <= '0;
         box_y1_ff     <= '0;
         pend_n_ff     <= '{default: '0};
         started_ff    <= '0;
         hold_valid_ff <= 1'b0;
         coll_cnt_ff   <= '0;
         last_ff       <= 1'b0;
         closing_ff    <= 1'b0;
         close_idx_ff  <= '0;
         cnt_ff        <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         box_x0_ff     <= box_x0_in;
         box_y0_ff     <= box_y0_in;
         box_x1_ff     <= box_x1_in;
         box_y1_ff     <= box_y1_in;
         pend_n_ff     <= pend_n_in;
         started_ff    <= started_in;
         hold_valid_ff <= hold_valid_in;
         coll_cnt_ff   <= coll_cnt_in;
         last_ff       <= last_in;
         closing_ff    <= closing_in;
         close_idx_ff  <= close_idx_in;
         cnt_ff        <= cnt_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_x_ff    <= pend_x_in;
      pend_y_ff    <= pend_y_in;
      first_x_ff   <= first_x_in;
      first_y_ff   <= first_y_in;
      prev_x_ff    <= prev_x_in;
      prev_y_ff    <= prev_y_in;
      hold_x_ff    <= hold_x_in;
      hold_y_ff    <= hold_y_in;
      ed_lvl_ff    <= ed_lvl_in;
      ed_qx_ff     <= ed_qx_in;
      ed_qy_ff     <= ed_qy_in;
      ed_qin_ff    <= ed_qin_in;
      ed_b_ff      <= ed_b_in;
      ed_o1_ff     <= ed_o1_in;
      ed_neg_ff    <= ed_neg_in;
      ed_ud_ff     <= ed_ud_in;
      ed_uc_ff     <= ed_uc_in;
      acc_ff       <= acc_in;
      rem_ff       <= rem_in;
      out_x_ff     <= out_x_in;
      out_y_ff     <= out_y_in;
      out_last_ff  <= out_last_in;
      out_empty_ff <= out_empty_in;
   end

endmodule

`default_nettype wire

// ===== hdl/rpc_checker.sv =====
// Port-level checks of the polygon clipper, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module rpc_checker (
   input wire logic  clock,
   input wire logic  reset,
   rpc_req_if.sink   req_bus,
   rpc_rsp_if.source rsp_bus
);

   // a stalled result transaction keeps its coordinates
   `RPC_ASSERT(a_rsp_hold, clock, reset, rsp_bus.valid && !rsp_bus.ready |=> rsp_bus.valid && $stable(rsp_bus.out_x) && $stable(rsp_bus.out_y))

   // an empty polygon ends the polygon and carries zero coordinates
   `RPC_ASSERT(a_empty_form, clock, reset, rsp_bus.valid && rsp_bus.empty_result |-> rsp_bus.out_last && rsp_bus.out_x == '0 && rsp_bus.out_y == '0)

   // one vertex in flight: ready drops after every accepted vertex
   `RPC_ASSERT(a_one_vertex, clock, reset, req_bus.valid && req_bus.ready |=> !req_bus.ready)

   // reset leaves the block idle with no result pending
   `RPC_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !rsp_bus.valid && req_bus.ready)

endmodule

bind rect_polygon_clipper rpc_checker u_rpc_checker (
   .clock   (clock),
   .reset   (reset),
   .req_bus (req_bus),
   .rsp_bus (rsp_bus)
);

`default_nettype wire

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the rectangle polygon clipper.
`timescale 1ns / 1ps
`default_nettype none

module tb;
   import rpc_pkg::*;

   localparam int CB = 16;

   typedef struct packed {
      logic signed [CB-1:0] x;
      logic signed [CB-1:0] y;
      logic                 last;
      logic                 empty;
   } clip_vtx_type;

   typedef struct {
      logic signed [CB-1:0] x;
      logic signed [CB-1:0] y;
      logic                 last;
      logic                 chk;
      clip_vtx_type         exp_vtx;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [REG_IDX_W-1:0] csr_index = '0;
   logic [CB-1:0] csr_wdata = '0;

   rpc_req_if #(.COORD_BITS(CB)) req_bus ();
   rpc_rsp_if #(.COORD_BITS(CB)) rsp_bus ();

   rect_polygon_clipper #(.COORD_BITS(CB)) u_dut (
      .clock(clock), .reset(reset), .req_bus(req_bus.sink), .rsp_bus(rsp_bus.source),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Predictor state
   longint box_reg[4];
   longint lim[4];
   longint first_x[4], first_y[4], prev_x[4], prev_y[4];
   bit     started[4];
   bit     held_ok;
   longint held_x, held_y;
   longint gath_x[$], gath_y[$];

   clip_vtx_type clip_expq[$];
   int  n_fail = 0;
   bit  quiet_tail = 0;
   bit  rsp_hold = 0;
   int  rsp_hold_len = 0;

   function automatic longint sx(longint v);
      logic signed [CB-1:0] t;
      t = v[CB-1:0];
      return longint'(t);
   endfunction

   function automatic longint cross_at(longint a1, longint o1, longint a2, longint o2,
                                       longint b);
      longint da, dc, dd, q, r, base;
      bit neg;
      da = b - a1; dc = o2 - o1; dd = a2 - a1;
      neg = (da < 0) ^ (dc < 0) ^ (dd < 0);
      if (da < 0) da = -da;
      if (dc < 0) dc = -dc;
      if (dd < 0) dd = -dd;
      q = (da * dc) / dd;
      r = (da * dc) % dd;
      base = neg ? o1 - q : o1 + q;
      if (r == 0) return base;
      if (!neg) return base >= 0 ? base : base + 1;
      return base > 0 ? base - 1 : base;
   endfunction

   function automatic bit in_side(int s, longint x, longint y);
      case (s)
         0: return x >= lim[0];
         1: return x <= lim[1];
         2: return y >= lim[2];
         default: return y <= lim[3];
      endcase
   endfunction

   function automatic void gather(longint x, longint y);
      if (gath_x.size() < MAX_OUT) begin
         gath_x = {gath_x, x};
         gath_y = {gath_y, y};
      end
   endfunction

   function automatic void clip_edge(int s, longint px, longint py, longint qx, longint qy);
      bit pin, qin;
      longint ix, iy;
      pin = in_side(s, px, py);
      qin = in_side(s, qx, qy);
      ix = px; iy = py;
      if (pin != qin) begin
         if (s < 2) begin
            if (qx != px) begin
               ix = lim[s]; iy = cross_at(px, py, qx, qy, lim[s]);
            end
         end else if (qy != py) begin
            iy = lim[s]; ix = cross_at(py, px, qy, qx, lim[s]);
         end
      end
      if (pin && qin) feed_stage(s + 1, qx, qy);
      else if (pin) feed_stage(s + 1, ix, iy);
      else if (qin) begin
         feed_stage(s + 1, ix, iy);
         feed_stage(s + 1, qx, qy);
      end
   endfunction

   function automatic void feed_stage(int s, longint x, longint y);
      if (s >= 4) begin
         gather(x, y);
         return;
      end
      if (!started[s]) begin
         started[s] = 1;
         first_x[s] = x; first_y[s] = y;
      end else
         clip_edge(s, prev_x[s], prev_y[s], x, y);
      prev_x[s] = x; prev_y[s] = y;
   endfunction

   function automatic void close_stages();
      for (int s = 0; s < 4; s++)
         if (started[s]) begin
            started[s] = 0;
            clip_edge(s, prev_x[s], prev_y[s], first_x[s], first_y[s]);
         end
   endfunction

   // Compute and queue the clipped vertices caused by one input vertex.
   function automatic void predict_clip(longint vx, longint vy, bit lst);
      clip_vtx_type v;
      int n;
      lim[0] = box_reg[0] < box_reg[2] ? box_reg[0] : box_reg[2];
      lim[1] = box_reg[0] < box_reg[2] ? box_reg[2] : box_reg[0];
      lim[2] = box_reg[1] < box_reg[3] ? box_reg[1] : box_reg[3];
      lim[3] = box_reg[1] < box_reg[3] ? box_reg[3] : box_reg[1];
      gath_x.delete(); gath_y.delete();
      if (held_ok) gather(held_x, held_y);
      held_ok = 0;
      feed_stage(0, vx, vy);
      if (lst) close_stages();
      n = gath_x.size();
      if (!lst && n > 0) begin
         held_x = gath_x.pop_back();
         held_y = gath_y.pop_back();
         held_ok = 1;
         n--;
      end else if (lst && n == 0) begin
         v.x = '0; v.y = '0; v.last = 1; v.empty = 1;
         clip_expq = {clip_expq, v};
         return;
      end
      for (int i = 0; i < n; i++) begin
         v.x = gath_x[i][CB-1:0];
         v.y = gath_y[i][CB-1:0];
         v.last = lst && (i == n - 1);
         v.empty = 0;
         clip_expq = {clip_expq, v};
      end
   endfunction

   task automatic write_box(rpc_reg_type idx, longint val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val[CB-1:0];
      @(negedge clock);
      box_reg[idx] = sx(val);
   endtask

   task automatic set_box(longint x0, longint y0, longint x1, longint y1);
      write_box(REG_BOX_X0, x0);
      write_box(REG_BOX_Y0, y0);
      write_box(REG_BOX_X1, x1);
      write_box(REG_BOX_Y1, y1);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   // Wait until all expected vertices arrived, then let the pipeline drain.
   task automatic drain_results();
      req_bus.valid <= 1'b0;
      while (clip_expq.size() != 0) @(negedge clock);
      repeat (400) @(negedge clock);
   endtask

   task automatic send_vertex(longint vx, longint vy, bit lst);
      if (!quiet_tail && $urandom_range(0, 5) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.vertex_x <= vx[CB-1:0];
      req_bus.vertex_y <= vy[CB-1:0];
      req_bus.last_vertex <= lst;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      predict_clip(sx(vx), sx(vy), lst);
      @(negedge clock);
   endtask

   function automatic longint rnd_coord(bit wide);
      if (wide) return sx(longint'($urandom));
      return longint'($urandom_range(0, 400)) - 200;
   endfunction

   // Directed table: expected vertex typed in where obvious, else predictor.
   stim_row_type dir_rows[$];

   function automatic stim_row_type mk(longint x, longint y, bit l, bit c = 0,
                                       longint ex = 0, longint ey = 0, bit el = 0,
                                       bit ee = 0);
      stim_row_type r;
      r.x = x[CB-1:0]; r.y = y[CB-1:0]; r.last = l; r.chk = c;
      r.exp_vtx.x = ex[CB-1:0]; r.exp_vtx.y = ey[CB-1:0];
      r.exp_vtx.last = el; r.exp_vtx.empty = ee;
      return r;
   endfunction

   initial begin
      req_bus.valid = 1'b0;
      req_bus.vertex_x = '0;
      req_bus.vertex_y = '0;
      req_bus.last_vertex = 1'b0;
      foreach (box_reg[i]) box_reg[i] = 0;
      foreach (started[i]) started[i] = 0;
      held_ok = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Box at reset is the origin point: a single vertex there survives.
      dir_rows = {dir_rows, mk(0, 0, 1, 1, 0, 0, 1, 0)};
      // Far-off single vertex is clipped away.
      dir_rows = {dir_rows, mk(32767, -32768, 1, 1, 0, 0, 1, 1)};
      foreach (dir_rows[i]) begin
         send_vertex(dir_rows[i].x, dir_rows[i].y, dir_rows[i].last);
         if (dir_rows[i].chk) begin
            if (clip_expq.size() == 0 || clip_expq[$] != dir_rows[i].exp_vtx) begin
               $error("table row %0d: expected %p actual prediction %p", i,
                      dir_rows[i].exp_vtx, clip_expq[$]);
               n_fail++;
            end
         end
      end
      drain_results();

      // Swapped corners, triangle crossing all edges, extremes.
      set_box(100, 100, -100, -100);
      send_vertex(-32768, 0, 0);
      send_vertex(32767, 32767, 0);
      send_vertex(0, -32768, 1);
      send_vertex(50, 50, 0);
      send_vertex(-50, 50, 0);
      send_vertex(0, -50, 1);
      send_vertex(150, 150, 0);
      send_vertex(200, 200, 1);
      // Star with many crossings to push the per-step result limit.
      for (int k = 0; k < 12; k++)
         send_vertex((k % 2) ? 32767 : -32768, (k % 4 < 2) ? 32767 : -32768, k == 11);
      drain_results();

      set_box(-32768, -32768, 32767, 32767);
      send_vertex(-32768, -32768, 0);
      send_vertex(32767, -1, 0);
      send_vertex(-1, 32767, 1);
      drain_results();

      // Random polygons with box changes between phases.
      for (int ph = 0; ph < 8; ph++) begin
         int items;
         items = 0;
         if (ph == 7) quiet_tail = 1;
         if (ph == 2) begin
            // Long receiver stall while vertices keep coming.
            rsp_hold_len = 300;
            rsp_hold = 1;
         end
         if (ph == 6) set_box(0, 0, 0, 0);
         else set_box(rnd_coord(ph == 5), rnd_coord(ph == 5),
                      rnd_coord(ph == 5), rnd_coord(ph == 5));
         while (items < 36) begin
            int nv;
            nv = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 7);
            for (int k = 0; k < nv; k++) begin
               send_vertex(rnd_coord(ph == 4 || $urandom_range(0, 7) == 0),
                           rnd_coord(ph == 4 || $urandom_range(0, 7) == 0), k == nv - 1);
               items++;
            end
            if (ph == 3 && items < 10) begin
               // Sender waits for all results before going on.
               req_bus.valid <= 1'b0;
               @(negedge clock);
               while (clip_expq.size() != 0) @(negedge clock);
            end
         end
         drain_results();
      end

      if (n_fail == 0)
         $display("tb OK");
      else
         $display("tb NOT OK");
      $finish;
   end

   // Result receiver with random stalls and one long hold-off.
   initial begin
      rsp_bus.ready = 1'b0;
      @(negedge clock);
      forever begin
         if (rsp_hold) begin
            rsp_bus.ready <= 1'b0;
            repeat (rsp_hold_len) @(negedge clock);
            rsp_hold = 0;
         end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge clock);
         end else begin
            rsp_bus.ready <= 1'b1;
            @(negedge clock);
         end
      end
   end

   always @(posedge clock) begin
      clip_vtx_type e;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (clip_expq.size() == 0) begin
            $error("unexpected result x=%0d y=%0d", rsp_bus.out_x, rsp_bus.out_y);
            n_fail++;
         end else begin
            e = clip_expq.pop_front();
            if (rsp_bus.out_x !== e.x) begin
               $error("out_x expected %0d actual %0d", e.x, rsp_bus.out_x);
               n_fail++;
            end
            if (rsp_bus.out_y !== e.y) begin
               $error("out_y expected %0d actual %0d", e.y, rsp_bus.out_y);
               n_fail++;
            end
            if (rsp_bus.out_last !== e.last) begin
               $error("out_last expected %0b actual %0b", e.last, rsp_bus.out_last);
               n_fail++;
            end
            if (rsp_bus.empty_result !== e.empty) begin
               $error("empty_result expected %0b actual %0b", e.empty,
                      rsp_bus.empty_result);
               n_fail++;
            end
         end
      end
   end

   initial begin
      #50ms;
      $display("tb NOT OK");
      $finish;
   end

endmodule

`default_nettype wire
